// ===== src/assert_macros.svh =====
// Assertion macros used by the back end of the checksum core.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Whenever cond holds at a clock edge, prop must hold at that same edge.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");

// Whenever cond holds at a clock edge, prop must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== src/fsc_pkg.sv =====
`timescale 1ns / 1ps

package fsc_pkg;

  // One byte of the file on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } fsc_in_t;

  // Result of one file on the output channel.
  typedef struct packed {
    logic [30:0] checksum;
    logic        signature_found;
    logic        signature_mismatch;
    logic        text_rejected;
  } fsc_out_t;

  // A classified byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       text_mode;
    logic       non_text;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       white;
  } fsc_item_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [30:0] HASH_RESET = 31'd1;

  // Signature line layout positions.
  localparam logic [5:0] POS_PREFIX_LAST = 6'd13;
  localparam logic [5:0] POS_HEX_FIRST   = 6'd14;
  localparam logic [5:0] POS_HEX_LAST    = 6'd21;
  localparam logic [5:0] POS_SPACE_A     = 6'd22;
  localparam logic [5:0] POS_DATE_FIRST  = 6'd23;
  localparam logic [5:0] POS_DATE_LAST   = 6'd33;
  localparam logic [5:0] POS_SPACE_B     = 6'd34;
  localparam logic [5:0] POS_STAR        = 6'd35;
  localparam logic [5:0] POS_SLASH       = 6'd36;
  localparam logic [5:0] SIG_LEN         = 6'd37;
  localparam logic [5:0] LINE_CAP        = 6'd40;

  // Character codes.
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_MIN_OK  = 8'h07;
  localparam logic [7:0] CHAR_HIGH    = 8'h80;
  localparam logic [7:0] CHAR_COPY    = 8'hA9;
  localparam logic [7:0] CHAR_CEDILLA = 8'hB8;

  // Literal prefix of a signature line, by position 0 to 13.
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "/";
      4'd1:    ch = "*";
      4'd2:    ch = " ";
      4'd3:    ch = "S";
      4'd4:    ch = "i";
      4'd5:    ch = "g";
      4'd6:    ch = "n";
      4'd7:    ch = "a";
      4'd8:    ch = "t";
      4'd9:    ch = "u";
      4'd10:   ch = "r";
      4'd11:   ch = "e";
      4'd12:   ch = ":";
      4'd13:   ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/fsc_front.sv =====
`timescale 1ns / 1ps

module fsc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  fsc_pkg::fsc_in_t  in_data,
  output fsc_pkg::fsc_item_t item
);
  import fsc_pkg::*;

  logic       binary_mode;
  logic [7:0] c;

  // Mode register; write it only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      binary_mode <= 1'b0;
    end else if (cfg_write) begin
      binary_mode <= cfg_data;
    end
  end

  assign c = in_data.data_byte;

  // Classify the incoming byte so the back end only has to look at flags.
  always_comb begin
    item.data_byte = c;
    item.last_byte = in_data.last_byte;
    item.text_mode = !binary_mode;
    item.non_text  = !binary_mode &&
                     (c < CHAR_MIN_OK ||
                      (c >= CHAR_HIGH && c != CHAR_COPY && c != CHAR_CEDILLA));
    item.white     = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    item.hex_ok    = 1'b1;
    item.hex_val   = 4'd0;
    if (c >= "0" && c <= "9") begin
      item.hex_val = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      item.hex_val = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      item.hex_val = 4'(c - 8'h37);
    end else begin
      item.hex_ok = 1'b0;
    end
  end

endmodule

// ===== src/fsc_queue.sv =====
`timescale 1ns / 1ps

module fsc_queue #(
  parameter int Depth = fsc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  fsc_pkg::fsc_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output fsc_pkg::fsc_item_t  pop_item
);
  import fsc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  fsc_item_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== src/fsc_back.sv =====
`timescale 1ns / 1ps

module fsc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  output logic               head_ready,
  input  fsc_pkg::fsc_item_t head,
  output logic               out_valid,
  input  logic               out_ready,
  output fsc_pkg::fsc_out_t  out_data
);
  import fsc_pkg::*;

  `include "assert_macros.svh"

  logic [30:0] hash,          hash_next;
  logic [30:0] saved_hash,    saved_hash_next;
  logic [5:0]  line_length,   line_length_next;
  logic        line_matches,  line_matches_next;
  logic [31:0] hex_acc,       hex_acc_next;
  logic        found_flag,    found_flag_next;
  logic [31:0] signed_value,  signed_value_next;
  logic        rejected_flag, rejected_flag_next;
  logic        pos_ok;
  logic        pop;
  fsc_out_t    result;

  // One step of the 31-bit shift-register hash.
  function automatic logic [30:0] mix_byte(input logic [30:0] h, input logic [7:0] b);
    logic [24:0] lo;
    lo = h[24:0];
    return {25'd0, h[30:25]} ^ {lo, 6'd0} ^ {3'd0, lo, 3'd0} ^ {23'd0, b};
  endfunction

  // A byte is taken unless it ends a file while out_valid is high and out_ready low.
  assign head_ready = !head.last_byte || !out_valid || out_ready;
  assign pop        = head_valid && head_ready;

  // Hash update, line tracking and signature matching for the head byte.
  always_comb begin
    hash_next          = hash;
    saved_hash_next    = saved_hash;
    line_length_next   = line_length;
    line_matches_next  = line_matches;
    hex_acc_next       = hex_acc;
    found_flag_next    = found_flag;
    signed_value_next  = signed_value;
    rejected_flag_next = rejected_flag;
    pos_ok             = 1'b0;

    if (pop && !rejected_flag) begin
      if (head.non_text) begin
        rejected_flag_next = 1'b1;
      end else begin
        hash_next = mix_byte(hash, head.data_byte);
        if (head.text_mode && !found_flag) begin
          if (head.data_byte == CHAR_NL) begin
            // End of line: accept it as the signature if it matched throughout.
            if (line_length == SIG_LEN && line_matches) begin
              found_flag_next   = 1'b1;
              signed_value_next = hex_acc;
              hash_next         = saved_hash;
            end
            saved_hash_next   = hash_next;
            line_length_next  = '0;
            line_matches_next = 1'b1;
            hex_acc_next      = '0;
          end else if (line_length < LINE_CAP) begin
            case (line_length) inside
              [6'd0:POS_PREFIX_LAST]: begin
                pos_ok = (head.data_byte == prefix_char(line_length[3:0]));
              end
              [POS_HEX_FIRST:POS_HEX_LAST]: begin
                pos_ok = head.hex_ok;
                if (head.hex_ok) begin
                  hex_acc_next = {hex_acc[27:0], head.hex_val};
                end
              end
              POS_SPACE_A, POS_SPACE_B: begin
                pos_ok = (head.data_byte == CHAR_SPACE);
              end
              [POS_DATE_FIRST:POS_DATE_LAST]: begin
                pos_ok = !head.white;
              end
              POS_STAR: begin
                pos_ok = (head.data_byte == CHAR_STAR);
              end
              POS_SLASH: begin
                pos_ok = (head.data_byte == CHAR_SLASH);
              end
              default: begin
                pos_ok = 1'b0;
              end
            endcase
            if (!pos_ok) begin
              line_matches_next = 1'b0;
            end
            line_length_next = line_length + 6'd1;
          end
        end
      end
    end

    result.checksum           = hash_next;
    result.signature_found    = found_flag_next;
    result.signature_mismatch = found_flag_next && (signed_value_next != {1'b0, hash_next});
    result.text_rejected      = rejected_flag_next;
  end

  // File state; it returns to its reset values after the last byte.
  always_ff @(posedge clk) begin
    if (rst || (pop && head.last_byte)) begin
      hash          <= HASH_RESET;
      saved_hash    <= HASH_RESET;
      line_length   <= '0;
      line_matches  <= 1'b1;
      hex_acc       <= '0;
      found_flag    <= 1'b0;
      signed_value  <= '0;
      rejected_flag <= 1'b0;
    end else begin
      hash          <= hash_next;
      saved_hash    <= saved_hash_next;
      line_length   <= line_length_next;
      line_matches  <= line_matches_next;
      hex_acc       <= hex_acc_next;
      found_flag    <= found_flag_next;
      signed_value  <= signed_value_next;
      rejected_flag <= rejected_flag_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last_byte) begin
      out_data <= result;
    end
  end

  `ASSERT_IMPLIES(a_len_capped, clk, rst, 1'b1, line_length <= LINE_CAP)
  `ASSERT_IMPLIES(a_found_no_line, clk, rst, found_flag, line_length == 6'd0)
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, pop && head.last_byte, !out_valid || out_ready)
  `ASSERT_NEXT(a_out_drains, clk, rst, out_valid && out_ready && !(pop && head.last_byte),
               !out_valid)

endmodule

// ===== src/file_signature_checksum_core.sv =====
`timescale 1ns / 1ps

// File signature checksum core. Bytes of one file arrive on the input channel, the
// final one flagged by last_byte; a single transfer on the output channel then carries
// the 31-bit checksum, the signature-found, mismatch and text-rejected flags, and the
// core starts over for the next file. In text mode (binary_mode = 0) a line laid out
// exactly as "/* Signature: HHHHHHHH DD-Mon-YYYY */" is left out of the hash and its
// hex value is compared against the final checksum. The core takes one byte per clock
// cycle: a front end classifies each byte, a QueueDepth-entry queue buffers it, and
// the back end updates the hash and line state for one byte per cycle, so the single
// back-end state update sets the rate. The result sits in an output register, so
// bytes of the next file keep flowing while it waits to be taken; only a second last
// byte stalls behind an untaken result. Write binary_mode only while the core is idle.
module file_signature_checksum_core #(
  parameter int QueueDepth = fsc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  fsc_pkg::fsc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fsc_pkg::fsc_out_t out_data
);
  import fsc_pkg::*;

  fsc_item_t front_item;
  fsc_item_t head_item;
  logic      head_valid;
  logic      head_ready;

  fsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .item      (front_item)
  );

  fsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  fsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .head       (head_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
